>>> rtl/core/urs_pkg.sv
package urs_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_TRIGGER_TICKS = 1'b0;
  localparam logic [7:0] TRIGGER_TICKS_RESET = 8'd8;

  localparam int WIDTH_W = 17;
  localparam int DIST_W = 11;
  localparam logic [WIDTH_W-1:0] SAT_WIDTH = 17'd118784;
  localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

  localparam int RECIP_W = 18;
  localparam int PROD_W = WIDTH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV58_RECIP = 18'd144632;
  localparam int DIV58_SHIFT = 23;

  typedef struct packed {
    logic                trigger;
    logic                ready;
    logic                measuring;
    logic                load;
    logic                sat;
    logic [WIDTH_W-1:0]  width;
  } urs_meas_t;

endpackage

>>> rtl/core/urs_ctrl.sv
module urs_ctrl #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                echo_level,
  input  logic                servo_settled,
  input  logic                run_enabled,
  input  logic                data_taken,
  input  logic [7:0]          trigger_ticks,
  output urs_pkg::urs_meas_t  meas
);
  import urs_pkg::*;

  localparam int WW = (COUNTER_WIDTH > WIDTH_W) ? COUNTER_WIDTH : WIDTH_W;

  typedef enum logic [1:0] {
    MODE_SERVO   = 2'd0,
    MODE_ECHO    = 2'd1,
    MODE_CONSUME = 2'd2
  } mode_t;

  mode_t                    mode, mode_next;
  logic [COUNTER_WIDTH-1:0] tick_count, tick_count_next, tick_inc;
  logic [COUNTER_WIDTH-1:0] rise_time, rise_time_next;
  logic [COUNTER_WIDTH-1:0] width;
  logic [WW-1:0]            width_ext;
  logic                     rise_seen, rise_seen_next;
  logic                     echo_previous;
  logic                     trigger_out, trigger_out_next;
  logic                     ready_flag, ready_flag_next;
  logic                     load;

  assign tick_inc  = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign width     = tick_inc - rise_time;
  assign width_ext = WW'(width);

  always_comb begin
    mode_next        = mode;
    tick_count_next  = tick_count;
    rise_time_next   = rise_time;
    rise_seen_next   = rise_seen;
    trigger_out_next = trigger_out;
    ready_flag_next  = ready_flag && !data_taken;
    load             = 1'b0;
    unique case (mode)
      MODE_SERVO: begin
        if (servo_settled && run_enabled && !ready_flag_next) begin
          tick_count_next  = '0;
          trigger_out_next = 1'b1;
          rise_seen_next   = 1'b0;
          mode_next        = MODE_ECHO;
        end
      end
      MODE_ECHO: begin
        tick_count_next = tick_inc;
        if (trigger_out && tick_inc >= COUNTER_WIDTH'(trigger_ticks)) begin
          trigger_out_next = 1'b0;
        end
        if (echo_level && !echo_previous && !rise_seen) begin
          rise_time_next = tick_inc;
          rise_seen_next = 1'b1;
        end else if (!echo_level && echo_previous && rise_seen) begin
          load             = 1'b1;
          ready_flag_next  = 1'b1;
          rise_seen_next   = 1'b0;
          trigger_out_next = 1'b0;
          mode_next        = MODE_CONSUME;
        end
      end
      MODE_CONSUME: begin
        if (!ready_flag_next) begin
          mode_next = MODE_SERVO;
        end
      end
      default: begin
        mode_next = MODE_SERVO;
      end
    endcase
  end

  always_comb begin
    meas.trigger   = trigger_out_next;
    meas.ready     = ready_flag_next;
    meas.measuring = (mode_next == MODE_ECHO);
    meas.load      = load;
    meas.sat       = (width_ext >= WW'(SAT_WIDTH));
    meas.width     = width_ext[WIDTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SERVO;
      tick_count    <= '0;
      rise_time     <= '0;
      rise_seen     <= 1'b0;
      echo_previous <= 1'b0;
      trigger_out   <= 1'b0;
      ready_flag    <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      tick_count    <= tick_count_next;
      rise_time     <= rise_time_next;
      rise_seen     <= rise_seen_next;
      echo_previous <= echo_level;
      trigger_out   <= trigger_out_next;
      ready_flag    <= ready_flag_next;
    end
  end

endmodule

>>> rtl/core/ultrasonic_range_sequencer.sv
// Channel   Dir  Beat
// s_axis    in   one microsecond tick: echo, servo settled, run enabled, data taken
// m_axis    out  one result per tick: trigger, distance_cm, ready, measuring
// apb       in   trigger_ticks at byte address 0
//
// One beat per cycle unless m_axis stalls; a result is registered in s1, then out.
// The control step finishes in the accept cycle; the divide by 58 is a
// reciprocal multiply in the second stage, which also holds the distance.
// Reset is synchronous and clears all control state; trigger_ticks returns to 8.
// A stall on m_axis holds both stages; s_axis stays ready while a stage is free.
module ultrasonic_range_sequencer #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urs_pkg::ADDR_W-1:0]  paddr,
  input  logic [urs_pkg::DATA_W-1:0]  pwdata,
  output logic [urs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [0] echo_level, [1] servo_settled, [2] run_enabled, [3] data_taken
  input  logic [7:0]                  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] trigger, [11:1] distance_cm, [12] measurement_ready, [13] measuring
  output logic [15:0]                 m_axis_tdata
);
  import urs_pkg::*;

  logic [7:0]         trigger_ticks;
  logic               s_accept;
  logic               out_move;
  urs_meas_t          meas;
  urs_meas_t          s1;
  logic               s1_valid;
  logic [PROD_W-1:0]  prod;
  logic [DIST_W-1:0]  quot;
  logic               out_valid;
  logic               out_trigger;
  logic [DIST_W-1:0]  distance;
  logic               out_ready_flag;
  logic               out_measuring;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRIGGER_TICKS) ? DATA_W'(trigger_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIGGER_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TRIGGER_TICKS) begin
      trigger_ticks <= pwdata[7:0];
    end
  end

  assign out_move      = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || out_move;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  urs_ctrl #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (s_accept),
    .echo_level   (s_axis_tdata[0]),
    .servo_settled(s_axis_tdata[1]),
    .run_enabled  (s_axis_tdata[2]),
    .data_taken   (s_axis_tdata[3]),
    .trigger_ticks(trigger_ticks),
    .meas         (meas)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (out_move) begin
      s1_valid <= 1'b0;
    end
    if (s_accept) begin
      s1 <= meas;
    end
  end

  assign prod = PROD_W'(s1.width) * PROD_W'(DIV58_RECIP);
  assign quot = prod[DIV58_SHIFT+DIST_W-1:DIV58_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      distance  <= '0;
    end else begin
      if (out_move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (out_move && s1.load) begin
        distance <= s1.sat ? DIST_MAX : quot;
      end
    end
    if (out_move) begin
      out_trigger    <= s1.trigger;
      out_ready_flag <= s1.ready;
      out_measuring  <= s1.measuring;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_measuring, out_ready_flag, distance, out_trigger};

endmodule

>>> tb/ultrasonic_range_sequencer_checker.sv
`default_nettype none

module ultrasonic_range_sequencer_checker #(
  parameter int CW = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [urs_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [urs_pkg::DATA_W-1:0]  pwdata,
  input  wire logic                        pready,
  input  wire logic                        s_axis_tvalid,
  input  wire logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,
  input  wire logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic [15:0]                 m_axis_tdata,
  output int                               pending,
  output int                               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [urs_pkg::ADDR_W-1:0] TICKS_ADDR =
    urs_pkg::ADDR_W'(4 * urs_pkg::REG_TRIGGER_TICKS);
  localparam int US_PER_CM = 58;

  typedef enum logic [1:0] {
    AWAIT_SERVO,
    AWAIT_ECHO,
    AWAIT_TAKE
  } ranger_mode_t;

  typedef struct packed {
    logic [1:0]                 pad;
    logic                       measuring;
    logic                       ready;
    logic [urs_pkg::DIST_W-1:0] distance_cm;
    logic                       trigger;
  } reading_t;

  ranger_mode_t               mode_q;
  logic [CW-1:0]              ticks_q;
  logic [CW-1:0]              rise_q;
  logic                       rise_seen_q;
  logic                       echo_q;
  logic                       trig_q;
  logic [urs_pkg::DIST_W-1:0] dist_q;
  logic                       ready_q;
  logic [7:0]                 trigger_len;

  reading_t pending_readings[$];

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic next_reading(input logic [3:0] f, output reading_t r);
    logic          echo;
    logic          settled;
    logic          running;
    logic          taken;
    logic [CW-1:0] pulse;
    int            cm;
    echo    = f[0];
    settled = f[1];
    running = f[2];
    taken   = f[3];
    if (taken) ready_q = 1'b0;
    case (mode_q)
      AWAIT_SERVO: begin
        if (settled && running && !ready_q) begin
          ticks_q     = '0;
          trig_q      = 1'b1;
          rise_seen_q = 1'b0;
          mode_q      = AWAIT_ECHO;
        end
      end
      AWAIT_ECHO: begin
        if (ticks_q != {CW{1'b1}}) ticks_q = ticks_q + 1'b1;
        if (trig_q && ticks_q >= trigger_len) trig_q = 1'b0;
        if (echo && !echo_q && !rise_seen_q) begin
          rise_q      = ticks_q;
          rise_seen_q = 1'b1;
        end else if (!echo && echo_q && rise_seen_q) begin
          pulse       = ticks_q - rise_q;
          cm          = int'(pulse) / US_PER_CM;
          dist_q      = (cm > int'(urs_pkg::DIST_MAX)) ? urs_pkg::DIST_MAX
                                                       : urs_pkg::DIST_W'(cm);
          ready_q     = 1'b1;
          rise_seen_q = 1'b0;
          trig_q      = 1'b0;
          mode_q      = AWAIT_TAKE;
        end
      end
      AWAIT_TAKE: begin
        if (!ready_q) mode_q = AWAIT_SERVO;
      end
      default: begin
        mode_q = AWAIT_SERVO;
      end
    endcase
    echo_q        = echo;
    r.pad         = '0;
    r.trigger     = trig_q;
    r.distance_cm = dist_q;
    r.ready       = ready_q;
    r.measuring   = (mode_q == AWAIT_ECHO);
  endtask

  always @(posedge clk) begin : watch
    reading_t want;
    reading_t got;
    if (rst) begin
      mode_q      = AWAIT_SERVO;
      ticks_q     = '0;
      rise_q      = '0;
      rise_seen_q = 1'b0;
      echo_q      = 1'b0;
      trig_q      = 1'b0;
      dist_q      = '0;
      ready_q     = 1'b0;
      trigger_len = urs_pkg::TRIGGER_TICKS_RESET;
      pending_readings.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TICKS_ADDR)
        trigger_len = pwdata[7:0];
      if (s_axis_tvalid && s_axis_tready) begin
        next_reading(s_axis_tdata[3:0], want);
        pending_readings.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_readings.size() == 0) begin
          report($sformatf("result beat 0x%04h with nothing outstanding", m_axis_tdata));
        end else begin
          want = pending_readings.pop_front();
          if (got.trigger !== want.trigger)
            report($sformatf("trigger got %b want %b", got.trigger, want.trigger));
          if (got.distance_cm !== want.distance_cm)
            report($sformatf("distance_cm got %0d want %0d",
                             got.distance_cm, want.distance_cm));
          if (got.ready !== want.ready)
            report($sformatf("measurement_ready got %b want %b", got.ready, want.ready));
          if (got.measuring !== want.measuring)
            report($sformatf("measuring got %b want %b", got.measuring, want.measuring));
          if (got.pad !== want.pad)
            report($sformatf("tdata padding got %b want 00", got.pad));
        end
      end
    end
    pending = pending_readings.size();
  end

endmodule

`default_nettype wire

>>> tb/ultrasonic_range_sequencer_test.sv
`default_nettype none

module ultrasonic_range_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [urs_pkg::ADDR_W-1:0] TICKS_ADDR =
    urs_pkg::ADDR_W'(4 * urs_pkg::REG_TRIGGER_TICKS);
  localparam int RANDOM_TICKS = 1900;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [urs_pkg::ADDR_W-1:0] paddr = '0;
  logic [urs_pkg::DATA_W-1:0] pwdata = '0;
  logic [urs_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // [0] echo_level, [1] servo_settled, [2] run_enabled, [3] data_taken
  logic [7:0]                 s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [0] trigger, [11:1] distance_cm, [12] measurement_ready, [13] measuring
  logic [15:0]                m_axis_tdata;

  int pending;
  int mismatches;
  int ticks_sent = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  ultrasonic_range_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ultrasonic_range_sequencer_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .mismatches    (mismatches)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("ultrasonic_range_sequencer_test: errors");
    $finish;
  end

  // stall the result side in short bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_tick(input bit echo, input bit settled, input bit running,
                           input bit taken);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, taken, running, settled, echo};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic write_trigger_ticks(input logic [7:0] len);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= TICKS_ADDR;
    pwdata  <= {24'b0, len};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // bring any open measurement to completion and release it
  task automatic flush_ranger();
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic measure(input int lead, input int pulse, input int hold,
                         input bit taken_on_fall);
    repeat ($urandom_range(0, 3))
      send_tick(coin(), coin(), 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    repeat (lead)
      send_tick($urandom_range(0, 15) == 0, coin(), coin(),
                $urandom_range(0, 7) == 0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    repeat (pulse + 1)
      send_tick(1'b1, coin(), coin(), 1'b0);
    send_tick(1'b0, coin(), coin(), taken_on_fall);
    repeat (hold)
      send_tick(coin(), coin(), coin(), 1'b0);
    send_tick(coin(), coin(), coin(), 1'b1);
  endtask

  task automatic random_phase(input int stop_at);
    int pick;
    int lead;
    int pulse;
    while (ticks_sent < stop_at) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 30))
          send_tick(coin(), coin(), coin(), coin());
      end else begin
        pick  = $urandom_range(0, 19);
        pulse = (pick < 16) ? $urandom_range(0, 150) :
                (pick < 19) ? $urandom_range(150, 900) : $urandom_range(900, 4000);
        lead  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 300)
                                            : $urandom_range(0, 12);
        measure(lead, pulse, $urandom_range(0, 6), $urandom_range(0, 4) == 0);
      end
      if ($urandom_range(0, 15) == 0) begin
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end
  endtask

  initial begin
    logic [7:0] lengths[5];
    lengths = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 254)),
                8'($urandom_range(1, 40))};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    // echo already high when the trigger starts
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    // fall with no rise seen
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    // consumer takes on the completing tick
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (120) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);

    foreach (lengths[p]) begin
      write_trigger_ticks(lengths[p]);
      random_phase(ticks_sent + RANDOM_TICKS / 5);
    end

    // close with one full measurement, no idling from here on
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_trigger_ticks(urs_pkg::TRIGGER_TICKS_RESET);
    flush_ranger();
    measure(100, 300, 2, 1'b0);
    repeat (60)
      send_tick(coin(), coin(), coin(), coin());

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ultrasonic_range_sequencer_test: clean");
    end else begin
      $display("ultrasonic_range_sequencer_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
